// ===== rtl/ptss_pkg.sv =====
// Shared types and constants for the periodic tick subscriber scheduler.
package ptss_pkg;

   // Field widths.
   localparam int ID_W     = 8;
   localparam int PERIOD_W = 16;
   localparam int COUNT_W  = 32;

   // Default table depth.
   localparam int MAX_SUBSCRIBERS_DEF = 16;

   // Request action codes.
   localparam logic ACTION_TICK      = 1'b0;
   localparam logic ACTION_SUBSCRIBE = 1'b1;

   // Result kind codes.
   typedef enum logic [1:0] {
      KIND_EXPIRY   = 2'd0,
      KIND_ACCEPTED = 2'd1,
      KIND_FULL     = 2'd2
   } kind_type;

   // One request transaction.
   typedef struct packed {
      logic                action;
      logic [ID_W-1:0]     subscriber_id;
      logic [PERIOD_W-1:0] period_ticks;
   } req_type;

   // One result transaction.
   typedef struct packed {
      kind_type        kind;
      logic [ID_W-1:0] notified_id;
      logic            last_of_run;
   } rsp_type;

   // One subscription table entry.
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
   } entry_type;

   // Status reported by the serial remainder unit.
   typedef struct packed {
      logic done;
      logic divisible;
   } div_status_type;

endpackage

// ===== rtl/ptss_mod_serial.sv =====
// Bit-serial remainder unit: tests whether the tick count is a multiple of a period.
module ptss_mod_serial (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptss_pkg::COUNT_W-1:0]  dividend,
   input  logic [ptss_pkg::PERIOD_W-1:0] divisor,
   output ptss_pkg::div_status_type      status
);
   import ptss_pkg::*;

   localparam int STEP_W = $clog2(COUNT_W);

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0]  dividend_ff, dividend_in;
   logic [PERIOD_W-1:0] divisor_ff, divisor_in;

   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;
   logic                fits;

   // One restoring step: bring in the next dividend bit and subtract if it fits.
   assign trial = {rem_ff, dividend_ff[COUNT_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      active_in   = active_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      rem_in      = rem_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      if (start) begin
         active_in   = 1'b1;
         step_in     = '0;
         rem_in      = '0;
         dividend_in = dividend;
         divisor_in  = divisor;
      end else if (active_ff) begin
         rem_in      = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         dividend_in = {dividend_ff[COUNT_W-2:0], 1'b0};
         step_in     = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(COUNT_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
   end

   // A zero period never divides anything.
   assign status.done      = done_ff;
   assign status.divisible = done_ff && (rem_ff == '0) && (divisor_ff != '0);

endmodule

// ===== rtl/periodic_tick_subscriber_scheduler.sv =====
// Top level of the periodic tick subscriber scheduler.
//
// A subscribe transaction is taken while busy is low and its single result appears on the next
// cycle; busy stays low, so another transaction may follow at once. A tick transaction
// advances the 32-bit counter and then walks the subscription table one entry at a time:
// each entry takes a table read, a load, and a pass through the bit-serial remainder
// unit, which retires one dividend bit per cycle, and a closing state ends the walk;
// busy stays high for the whole walk, and stays low when the table is empty. Expiry
// results come out in table order while the walk goes on; each is held until the next
// match or the end of the walk so that the final one carries last_of_run. Every result
// is on the rsp_ ports for exactly one cycle, marked by rsp_valid, and must be taken
// then: the receiver cannot stall the block.
module periodic_tick_subscriber_scheduler #(
   parameter int MAX_SUBSCRIBERS = ptss_pkg::MAX_SUBSCRIBERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptss_pkg::req_type req_item,
   output logic              rsp_valid,
   output ptss_pkg::rsp_type rsp_item
);
   import ptss_pkg::*;

   localparam int IDX_W = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
   localparam int CNT_W = $clog2(MAX_SUBSCRIBERS + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FETCH  = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic [ID_W-1:0]    cur_id_ff, cur_id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   entry_type          table_mem [MAX_SUBSCRIBERS];
   entry_type          rd_ff;
   entry_type          wr_entry;
   logic               mem_we;

   logic               accept;
   logic [CNT_W-1:0]   idx_next;
   logic               div_start;
   div_status_type     div_status;

   assign accept   = start && !busy;
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign wr_entry = '{id: req_item.subscriber_id, period: req_item.period_ticks};

   // Serial remainder of the tick count by the current entry's period.
   ptss_mod_serial u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (count_ff),
      .divisor  (rd_ff.period),
      .status   (div_status)
   );

   // Subscription table: appended at the fill count, read at the walk index.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[used_ff[IDX_W-1:0]] <= wr_entry;
      end
      rd_ff <= table_mem[idx_ff];
   end

   // Sequencer for subscribe handling and the tick walk.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      cur_id_in     = cur_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      div_start     = 1'b0;
      mem_we        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.action == ACTION_SUBSCRIBE) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.notified_id = req_item.subscriber_id;
                  rsp_in.last_of_run = 1'b1;
                  if (used_ff < CNT_W'(MAX_SUBSCRIBERS)) begin
                     rsp_in.kind = KIND_ACCEPTED;
                     mem_we      = 1'b1;
                     used_in     = used_ff + CNT_W'(1);
                  end else begin
                     rsp_in.kind = KIND_FULL;
                  end
               end else begin
                  count_in = count_ff + COUNT_W'(1);
                  idx_in   = '0;
                  if (used_ff != '0) begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            div_start = 1'b1;
            cur_id_in = rd_ff.id;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               // A new match releases the one held before it.
               if (div_status.divisible) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.kind        = KIND_EXPIRY;
                     rsp_in.notified_id = pend_id_ff;
                     rsp_in.last_of_run = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = cur_id_ff;
               end
               if (idx_next == used_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in   = idx_next[IDX_W-1:0];
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FLUSH: begin
            // The match still held is the last of the run.
            if (pend_valid_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.kind        = KIND_EXPIRY;
               rsp_in.notified_id = pend_id_ff;
               rsp_in.last_of_run = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         used_ff       <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_id_ff <= pend_id_in;
      cur_id_ff  <= cur_id_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== sim/tb_periodic_tick_subscriber_scheduler.sv =====
// Self-checking testbench for the periodic tick subscriber scheduler.
`timescale 1ns / 100ps

module tb_periodic_tick_subscriber_scheduler;
   import ptss_pkg::*;

   localparam int TABLE_DEPTH  = MAX_SUBSCRIBERS_DEF;
   localparam int RANDOM_ITEMS = 195;
   localparam int PAUSE_AT     = 100;
   // The drain time covers a full tick walk over every table entry and its closing state.
   localparam int DRAIN_CYCLES = 35 * TABLE_DEPTH + 40;
   localparam int CYCLE_LIMIT  = 1000000;

   // Tracks the subscription table and tick counter, and holds the notices still owed.
   class notice_scoreboard;
      rsp_type               due_notices[$];
      logic [COUNT_W-1:0]    tick_total;
      int unsigned           entries;
      logic [ID_W-1:0]       entry_ids[TABLE_DEPTH];
      logic [PERIOD_W-1:0]   entry_periods[TABLE_DEPTH];
      int unsigned           mismatches;

      function new();
         tick_total = '0;
         entries    = 0;
         mismatches = 0;
      endfunction

      // Works out every result that an accepted request transaction will cause.
      function void note_request(req_type r);
         rsp_type     notice;
         rsp_type     hits[TABLE_DEPTH];
         int unsigned n;

         n = 0;
         if (r.action == ACTION_SUBSCRIBE) begin
            notice.notified_id = r.subscriber_id;
            notice.last_of_run = 1'b1;
            if (entries < TABLE_DEPTH) begin
               entry_ids[entries]     = r.subscriber_id;
               entry_periods[entries] = r.period_ticks;
               entries++;
               notice.kind = KIND_ACCEPTED;
            end else begin
               notice.kind = KIND_FULL;
            end
            due_notices = {due_notices, notice};
         end else begin
            tick_total = tick_total + 1;
            for (int i = 0; i < entries; i++) begin
               // A zero period is stored but never fires.
               if (entry_periods[i] != '0 &&
                   (tick_total % {16'd0, entry_periods[i]}) == '0) begin
                  hits[n].kind        = KIND_EXPIRY;
                  hits[n].notified_id = entry_ids[i];
                  hits[n].last_of_run = 1'b0;
                  n++;
               end
            end
            // Only the final notice of a run is marked.
            if (n > 0) hits[n-1].last_of_run = 1'b1;
            for (int i = 0; i < n; i++) due_notices = {due_notices, hits[i]};
         end
      endfunction

      // Compares one result transaction with the oldest notice still owed.
      function void check_notice(rsp_type r);
         rsp_type want;

         if (due_notices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d id %0d last %0d",
                        r.kind, r.notified_id, r.last_of_run);
         end else begin
            want = due_notices.pop_front();
            if (r.kind !== want.kind || r.notified_id !== want.notified_id ||
                r.last_of_run !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected kind %0d id %0d last %0d, ",
                            "got kind %0d id %0d last %0d"},
                           want.kind, want.notified_id, want.last_of_run,
                           r.kind, r.notified_id, r.last_of_run);
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   notice_scoreboard board = new();
   int unsigned      accepted_count = 0;
   int unsigned      cycles = 0;

   periodic_tick_subscriber_scheduler uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // Record accepted requests and check results on the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_request(req_item);
            accepted_count++;
         end
         if (rsp_valid) board.check_notice(rsp_item);
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("periodic_tick_subscriber_scheduler test failed");
         $finish;
      end
   end

   function automatic req_type make_req(logic action, logic [ID_W-1:0] id,
                                        logic [PERIOD_W-1:0] period);
      req_type r;

      r.action        = action;
      r.subscriber_id = id;
      r.period_ticks  = period;
      return r;
   endfunction

   // Presents one request transaction and returns on the falling edge after it is taken.
   task automatic send_item(req_type r);
      int unsigned seen;

      seen = accepted_count;
      start    <= 1'b1;
      req_item <= r;
      do @(negedge clock); while (accepted_count == seen);
   endtask

   // Random idle time between requests; every third stretch of 16 has none.
   task automatic idle_after(int unsigned k);
      int unsigned roll;
      int unsigned gap;

      roll = $urandom_range(0, 99);
      if ((k / 16) % 3 == 1 || roll < 45) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 60);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Mostly small periods so that expiries are frequent, with some zero and wide ones.
   function automatic logic [PERIOD_W-1:0] pick_period();
      int unsigned roll;

      roll = $urandom_range(0, 99);
      if (roll < 70) return PERIOD_W'($urandom_range(1, 12));
      else if (roll < 80) return '0;
      else return PERIOD_W'($urandom);
   endfunction

   req_type     directed[$];
   req_type     item;
   int unsigned k;

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: tick on an empty table, extreme ids and periods, zero period.
      directed = {directed, make_req(ACTION_TICK, 8'hFF, 16'hFFFF)};
      directed = {directed, make_req(ACTION_SUBSCRIBE, 8'h00, 16'h0000)};
      directed = {directed, make_req(ACTION_SUBSCRIBE, 8'hFF, 16'h0001)};
      directed = {directed, make_req(ACTION_SUBSCRIBE, 8'hA5, 16'hFFFF)};
      directed = {directed, make_req(ACTION_SUBSCRIBE, 8'h5A, 16'h0002)};
      directed = {directed, make_req(ACTION_SUBSCRIBE, 8'h3C, 16'h0003)};
      for (int i = 0; i < 6; i++)
         directed = {directed,
                     make_req(ACTION_TICK, ID_W'($urandom), PERIOD_W'($urandom))};
      directed = {directed, make_req(ACTION_SUBSCRIBE, 8'h81, 16'h0004)};
      directed = {directed, make_req(ACTION_TICK, 8'h00, 16'h0000)};
      directed = {directed, make_req(ACTION_TICK, 8'hFF, 16'hFFFF)};

      k = 0;
      foreach (directed[i]) begin
         send_item(directed[i]);
         idle_after(k);
         k++;
      end

      // Random part: the table fills up, after which subscriptions are dropped.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 20)
            item = make_req(ACTION_SUBSCRIBE, ID_W'($urandom), pick_period());
         else
            item = make_req(ACTION_TICK, ID_W'($urandom), PERIOD_W'($urandom));
         send_item(item);
         idle_after(k);
         k++;
         // Once in the run, hold off until every owed result has come back.
         if (i == PAUSE_AT) begin
            start <= 1'b0;
            while (board.due_notices.size() != 0) @(negedge clock);
         end
      end

      start <= 1'b0;
      while (board.due_notices.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (board.mismatches == 0 && board.due_notices.size() == 0) begin
         $display("periodic_tick_subscriber_scheduler test passed");
      end else begin
         $display("periodic_tick_subscriber_scheduler test failed");
      end
      $finish;
   end

endmodule
